[sv/tsiu_pkg.sv]
// Types and constants shared by the tag slot table.
package tsiu_pkg;

  localparam int CFG_W  = 4;
  localparam int INDEX_W = 3;

  typedef enum logic [1:0] {
    OUT_UPDATED  = 2'd0,
    OUT_INSERTED = 2'd1,
    OUT_FULL     = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [31:0] tag_space;
    logic [31:0] tag_database;
    logic [31:0] tag_relation;
    logic [3:0]  tag_fork;
    logic [31:0] tag_block;
    logic [63:0] epoch;
  } in_t;

  typedef struct packed {
    outcome_t             outcome;
    logic [INDEX_W-1:0]   slot_index;
  } out_t;

  typedef struct packed {
    logic [31:0] space;
    logic [31:0] database;
    logic [31:0] relation;
    logic [3:0]  fork_num;
    logic [31:0] block;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [63:0] epoch;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[sv/tsiu_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
module tsiu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/tag_slot_insert_or_update_top.sv]
// Tag slot table: searches parked tags and updates the epoch or inserts into a free slot.
// A request is taken in idle; done follows the scan (sooner on a tag hit), which covers
//   min(slot_limit, TABLE_SLOTS) slots, one entry RAM read each, pipelined, plus a decision.
// busy is high through the scan and no request is taken then; no free slot means OUT_FULL.
// The single entry RAM read port sets the scan rate; no result stall.
// Reset (rst, synchronous): valid bits cleared, slot_limit set to 8; RAM contents kept.
module tag_slot_insert_or_update_top #(
  parameter int TABLE_SLOTS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  tsiu_pkg::in_t            item,
  output logic                     done,
  output tsiu_pkg::out_t           result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [tsiu_pkg::CFG_W-1:0] cfg_data
);

  import tsiu_pkg::*;

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                 state;
  logic [CFG_W-1:0]       slot_limit;
  logic [CMP_W-1:0]       limit_q;
  in_t                    req_q;
  logic [TABLE_SLOTS-1:0] valid;
  logic [CNT_W-1:0]       cnt;
  logic                   pend;
  logic [IDX_W-1:0]       pend_idx;
  logic                   have_free;
  logic [IDX_W-1:0]       free_idx;

  logic                   issue;
  logic                   hit;
  logic                   finish;
  logic                   pend_free;
  logic                   ins_ok;
  logic [IDX_W-1:0]       ins_idx;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  entry_t                 wr_entry;
  logic [ENTRY_W-1:0]     rd_raw;
  entry_t                 rd_entry;
  tag_t                   req_tag;
  logic [CMP_W-1:0]       eff_limit;
  logic [IDX_W+INDEX_W-1:0] idx_wide;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  assign req_tag = '{space:    req_q.tag_space,
                     database: req_q.tag_database,
                     relation: req_q.tag_relation,
                     fork_num: req_q.tag_fork,
                     block:    req_q.tag_block};
  assign rd_entry = rd_raw;

  // Saturate the configured limit to the table size
  assign eff_limit = (CMP_W'(slot_limit) > CMP_W'(TABLE_SLOTS)) ?
                     CMP_W'(TABLE_SLOTS) : CMP_W'(slot_limit);

  always_comb begin
    issue     = (state == S_SCAN) && (CMP_W'(cnt) < limit_q);
    pend_free = pend && !valid[pend_idx];
    hit       = (state == S_SCAN) && pend && valid[pend_idx] && (rd_entry.tag == req_tag);
    finish    = (state == S_SCAN) && !hit && !issue;
    ins_ok    = have_free || pend_free;
    ins_idx   = have_free ? free_idx : pend_idx;
    wr_en     = hit || (finish && ins_ok);
    wr_addr   = hit ? pend_idx : ins_idx;
    wr_entry  = '{tag: req_tag, epoch: req_q.epoch};
    idx_wide  = (IDX_W + INDEX_W)'(wr_addr);
  end

  tsiu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (cnt[IDX_W-1:0]),
    .rd_data (rd_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_limit <= CFG_W'(8);
      valid      <= '0;
      done       <= 1'b0;
      pend       <= 1'b0;
      have_free  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        slot_limit <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_q     <= item;
            limit_q   <= eff_limit;
            cnt       <= '0;
            pend      <= 1'b0;
            have_free <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          priority if (hit) begin
            done              <= 1'b1;
            result.outcome    <= OUT_UPDATED;
            result.slot_index <= idx_wide[INDEX_W-1:0];
            pend              <= 1'b0;
            state             <= S_IDLE;
          end else if (finish) begin
            done  <= 1'b1;
            pend  <= 1'b0;
            state <= S_IDLE;
            if (ins_ok) begin
              valid[ins_idx]    <= 1'b1;
              result.outcome    <= OUT_INSERTED;
              result.slot_index <= idx_wide[INDEX_W-1:0];
            end else begin
              result.outcome    <= OUT_FULL;
              result.slot_index <= '0;
            end
          end else begin
            // lowest free slot seen so far
            if (pend_free && !have_free) begin
              have_free <= 1'b1;
              free_idx  <= pend_idx;
            end
            pend     <= issue;
            pend_idx <= cnt[IDX_W-1:0];
            if (issue) begin
              cnt <= cnt + CNT_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result strobe only follows a scan cycle, and the block is free again by then
  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_SCAN) && !busy)
    else $error("result strobe without a finished scan");

  a_full_index_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.outcome == OUT_FULL)) |-> (result.slot_index == '0))
    else $error("full result carries a nonzero slot index");

  a_pend_in_limit: assert property (@(posedge clk) disable iff (rst)
    pend |-> (CMP_W'(pend_idx) < limit_q))
    else $error("pending read beyond the slot limit");

  a_valid_grows_by_one: assert property (@(posedge clk) disable iff (rst)
    ($countones(valid) != $past($countones(valid))) |->
      (($countones(valid) == $past($countones(valid)) + 1) && $past(finish)))
    else $error("valid bits changed outside an insert");

  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_SCAN) && !issue || hit)
    else $error("entry write outside the end of a scan");

endmodule
